// ===== rtl/mac_activation_code_cipher_assert.svh =====
// Assertion macros used by the top level of the activation code cipher.
`ifndef MAC_ACTIVATION_CODE_CIPHER_ASSERT_SVH
`define MAC_ACTIVATION_CODE_CIPHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MACC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MACC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/macc_pkg.sv =====
// Shared types, constants and constant functions of the activation code cipher.
`default_nettype none

package macc_pkg;

  // Default number of Feistel rounds.
  localparam int ROUND_COUNT_DEF = 32;

  // Round constant and block framing bytes.
  localparam logic [31:0] DELTA       = 32'h9E3779B9;
  localparam logic [7:0]  FRAME_TOP    = 8'hAB;
  localparam logic [7:0]  FRAME_BOTTOM = 8'hCD;

  // Bit position of the key index in the second half round.
  localparam int KEY_SHIFT = 11;

  // Key register file.
  localparam int KEY_COUNT = 4;
  localparam int ADDR_W    = 4;
  localparam logic [KEY_COUNT-1:0][31:0] KEY_RESET = {32'd200, 32'd100, 32'd7, 32'd5};

  // Entries of the queue between front and back; a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [KEY_COUNT-1:0][31:0] key_set_t;

  // One input word: twelve ASCII characters.
  typedef struct packed {
    logic [47:0] mac_chars_high;
    logic [47:0] mac_chars_low;
  } macc_in_t;

  // One result word.
  typedef struct packed {
    logic        code_valid;
    logic [31:0] activation_code;
  } macc_out_t;

  // A decoded block on its way through the rounds.
  typedef struct packed {
    logic        ok;
    logic [31:0] y;
    logic [31:0] z;
  } macc_block_t;

  // Running sum after the given number of delta additions.
  function automatic logic [31:0] round_sum(input int steps);
    logic [63:0] prod;
    prod = 64'(steps) * 64'(DELTA);
    return prod[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/macc_regs.sv =====
// Key register file behind the APB-style configuration port.
`default_nettype none

module macc_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [macc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output macc_pkg::key_set_t                 key
);

  logic [1:0] key_sel;

  assign key_sel = paddr[3:2];
  assign pready  = 1'b1;

  // Write on the access cycle; the word address picks the key.
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= macc_pkg::KEY_RESET;
    end else if (psel && penable && pwrite) begin
      key[key_sel] <= pwdata;
    end
  end

  // Read data follows the address.
  assign prdata = key[key_sel];

endmodule

`default_nettype wire

// ===== rtl/macc_front.sv =====
// Front part: takes input words, checks and decodes the characters, frames the block.
`default_nettype none

module macc_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire macc_pkg::macc_in_t    item,
  output logic                       full,
  output logic                       q_push,
  output macc_pkg::macc_block_t      q_item,
  input  wire logic                  q_full
);

  logic [11:0]      char_ok;
  logic [11:0][3:0] nib;
  logic [95:0]      text;
  logic             hold_valid;
  macc_pkg::macc_block_t blk;

  // Hex character to nibble; letters of either case share the low bits.
  function automatic logic [4:0] decode_char(input logic [7:0] c);
    logic is_digit;
    logic is_letter;
    is_digit  = (c >= 8'h30) && (c <= 8'h39);
    is_letter = ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    if (is_digit) begin
      return {1'b1, c[3:0]};
    end else if (is_letter) begin
      return {1'b1, c[3:0] + 4'd9};
    end else begin
      return 5'd0;
    end
  endfunction

  assign text = {item.mac_chars_high, item.mac_chars_low};

  // Decode all twelve characters side by side.
  always_comb begin
    for (int p = 0; p < 12; p++) begin
      {char_ok[p], nib[p]} = decode_char(text[95 - 8*p -: 8]);
    end
  end

  // Frame the six bytes between the top and bottom marks.
  always_comb begin
    blk.ok = &char_ok;
    blk.y  = {macc_pkg::FRAME_TOP, nib[0], nib[1], nib[2], nib[3], nib[4], nib[5]};
    blk.z  = {nib[6], nib[7], nib[8], nib[9], nib[10], nib[11], macc_pkg::FRAME_BOTTOM};
  end

  // One holding register; it drains into the queue whenever the queue has room.
  assign full   = hold_valid && q_full;
  assign q_push = hold_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (push && !full) begin
      hold_valid <= 1'b1;
    end else if (!q_full) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      q_item <= blk;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/macc_queue.sv =====
// Short flop queue that decouples the front part from the round pipeline.
`default_nettype none

module macc_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire macc_pkg::macc_block_t wr_item,
  output logic                       q_full,
  input  wire logic                  rd_en,
  output macc_pkg::macc_block_t      rd_item,
  output logic                       q_empty
);

  macc_pkg::macc_block_t          slots [macc_pkg::QUEUE_DEPTH];
  logic [macc_pkg::QPTR_W-1:0]    wr_ptr;
  logic [macc_pkg::QPTR_W-1:0]    rd_ptr;
  logic [macc_pkg::QPTR_W:0]      count;

  assign q_full  = (count == (macc_pkg::QPTR_W + 1)'(macc_pkg::QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign rd_item = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/macc_back.sv =====
// Back part: unrolled Feistel rounds, one half round per stage, and the result register.
`default_nettype none

module macc_back #(
  parameter int ROUND_COUNT = macc_pkg::ROUND_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire macc_pkg::key_set_t    key,
  input  wire logic                  q_empty,
  input  wire macc_pkg::macc_block_t q_item,
  output logic                       q_pop,
  input  wire logic                  pop,
  output logic                       empty,
  output macc_pkg::macc_out_t        result
);

  localparam int STAGES = 2 * ROUND_COUNT;

  logic [STAGES-1:0]     vld;
  macc_pkg::macc_block_t stg [STAGES];
  logic                  out_valid;
  logic                  adv;

  // The whole pipeline moves when the result register is free or being taken.
  assign adv   = !out_valid || pop;
  assign q_pop = adv && !q_empty;
  assign empty = !out_valid;

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    macc_pkg::macc_block_t src;
    logic                  src_v;
    macc_pkg::macc_block_t nxt;

    if (k == 0) begin : g_head
      assign src   = q_item;
      assign src_v = !q_empty;
    end else begin : g_chain
      assign src   = stg[k-1];
      assign src_v = vld[k-1];
    end

    if ((k % 2) == 0) begin : g_y_half
      // First half: update y from z, key chosen by the low bits of the sum.
      localparam logic [31:0] SUM = macc_pkg::round_sum(k / 2);
      localparam logic [1:0]  KI  = SUM[1:0];
      always_comb begin
        nxt    = src;
        nxt.y  = src.y + (((src.z << 4) ^ (src.z >> 5)) + (src.z ^ SUM) + key[KI]);
      end
    end else begin : g_z_half
      // Second half: update z from the new y, sum already advanced.
      localparam logic [31:0] SUM = macc_pkg::round_sum(k / 2 + 1);
      localparam logic [1:0]  KI  = SUM[macc_pkg::KEY_SHIFT +: 2];
      always_comb begin
        nxt    = src;
        nxt.z  = src.z + (((src.y << 4) ^ (src.y >> 5)) + (src.y ^ SUM) + key[KI]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg[k] <= nxt;
      end
    end
  end

  // Result register: fold the halves, zero the code for a bad character.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.code_valid      <= stg[STAGES-1].ok;
      result.activation_code <= stg[STAGES-1].ok ?
                                (stg[STAGES-1].y ^ stg[STAGES-1].z) : 32'd0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mac_activation_code_cipher.sv =====
// Top level of the activation code cipher: input queue port, round pipeline, key registers.
//
// Input words carry twelve ASCII hex characters in two 48-bit fields. A word
// is taken at a rising edge with push high and full low. Results come out in
// order: while empty is low the oldest result stands on the result port and is
// taken at an edge with pop high. code_valid is 0 and the code is 0 when any
// character is not a hex digit.
// From accept to result shown, a word passes one front register, one queue
// slot, one pipeline stage per half round and the result register. While full
// is low a word can be accepted in every cycle; the rate is one word per
// cycle, set by the fully unrolled round pipeline.
// Once a result is waiting and pop stays low, the whole pipeline holds; the
// front register and the four-word queue keep taking words until they fill,
// then full rises.
// Reset (synchronous, active high) empties the queue and pipeline and loads
// the keys 5, 7, 100, 200. Keys are written over the APB-style port at byte
// addresses 0, 4, 8, 12 and should only change while no word is in flight.
`default_nettype none

`include "mac_activation_code_cipher_assert.svh"

module mac_activation_code_cipher #(
  parameter int ROUND_COUNT = macc_pkg::ROUND_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire macc_pkg::macc_in_t            item,
  output logic                               full,
  input  wire logic                          pop,
  output logic                               empty,
  output macc_pkg::macc_out_t                result,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [macc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  macc_pkg::key_set_t    key;
  macc_pkg::macc_block_t fq_item;
  macc_pkg::macc_block_t qb_item;
  logic                  fq_push;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;

  // Key registers.
  macc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key     (key)
  );

  // Character check and block framing.
  macc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .q_push (fq_push),
    .q_item (fq_item),
    .q_full (q_full)
  );

  // Decoupling queue.
  macc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fq_push),
    .wr_item (fq_item),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_item (qb_item),
    .q_empty (q_empty)
  );

  // Round pipeline and result register.
  macc_back #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .key     (key),
    .q_empty (q_empty),
    .q_item  (qb_item),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  // A rejected character always yields a zero code.
  `MACC_ASSERT_IMPLY(a_bad_code_zero, clk, rst, !empty && !result.code_valid,
                     result.activation_code == 32'd0, "invalid result with nonzero code")

  // The input side only backs up once the queue is full.
  `MACC_ASSERT_IMPLY(a_full_needs_queue_full, clk, rst, full, q_full,
                     "full raised with room in the queue")

  // The pipeline never pulls from an empty queue.
  `MACC_ASSERT_IMPLY(a_no_pop_when_empty, clk, rst, q_pop, !q_empty,
                     "pipeline read an empty queue")

  // A stalled result stays shown.
  `MACC_ASSERT_NEXT(a_stall_holds_result, clk, rst, !empty && !pop,
                    !empty && $stable(result), "stalled result changed")

endmodule

`default_nettype wire
